@@ hdl/tlec_pkg.sv @@
// ----------------------------------------------------------------------------
// tlec_pkg
// Types and codes shared by the crossing light controller and its next-state
// logic.
// ----------------------------------------------------------------------------
package tlec_pkg;

  localparam int TickW = 16;

  typedef enum logic [1:0] {
    REG_SHORT_TICKS     = 2'd0,
    REG_LONG_TICKS      = 2'd1,
    REG_EMERGENCY_TICKS = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    LAMP_RED = 2'd0,
    LAMP_YEL = 2'd1,
    LAMP_GRN = 2'd2
  } lamp_t;

  typedef enum logic [2:0] {
    PH_HOLD    = 3'd0,
    PH_NS_GRN  = 3'd1,
    PH_NS_YEL  = 3'd2,
    PH_NS_RED  = 3'd3,
    PH_EW_GRN  = 3'd4,
    PH_EW_YEL  = 3'd5,
    PH_EW_RED  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_NS_YEL = 3'd1,
    ST_EW_YEL = 3'd2,
    ST_NS_RED = 3'd3,
    ST_EW_RED = 3'd4
  } emg_step_t;

  typedef struct packed {
    logic tick;
    logic emergency_press;
  } item_t;

  typedef struct packed {
    logic [1:0] ns_light;
    logic [1:0] ew_light;
    logic       emergency_active;
  } result_t;

  typedef struct packed {
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] emergency_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    phase_t           last_phase;
    emg_step_t        step;
    logic             pending;
    logic [TickW-1:0] remaining;
  } ctl_state_t;

endpackage

@@ hdl/tlec_step.sv @@
// ----------------------------------------------------------------------------
// tlec_step
// Next-state and lamp logic for one transfer: press, tick, one pass of the
// phase and emergency rules, then lamp decode.
// ----------------------------------------------------------------------------
module tlec_step import tlec_pkg::*; (
  input  ctl_state_t cur,
  input  item_t      item,
  input  cfg_t       cfg,
  output ctl_state_t nxt,
  output result_t    result
);

  ctl_state_t s;
  lamp_t      ns;
  lamp_t      ew;

  always_comb begin
    s = cur;

    if (item.emergency_press) begin
      s.pending = 1'b1;
      s.phase   = PH_HOLD;
    end
    if (item.tick && s.remaining != '0) begin
      s.remaining = s.remaining - TickW'(1);
    end

    // normal cycle
    if (s.remaining == '0 && s.phase == PH_NS_GRN) begin
      s.phase = PH_NS_YEL; s.last_phase = PH_NS_YEL; s.remaining = cfg.short_ticks;
    end
    if (s.remaining == '0 && s.phase == PH_NS_YEL) begin
      s.phase = PH_NS_RED; s.last_phase = PH_NS_RED; s.remaining = cfg.short_ticks;
    end
    if (s.remaining == '0 && s.phase == PH_NS_RED) begin
      s.phase = PH_EW_GRN; s.last_phase = PH_EW_GRN; s.remaining = cfg.long_ticks;
    end
    if (s.remaining == '0 && s.phase == PH_EW_GRN) begin
      s.phase = PH_EW_YEL; s.last_phase = PH_EW_YEL; s.remaining = cfg.short_ticks;
    end
    if (s.remaining == '0 && s.phase == PH_EW_YEL) begin
      s.phase = PH_EW_RED; s.last_phase = PH_EW_RED; s.remaining = cfg.short_ticks;
    end
    if (s.remaining == '0 && s.phase == PH_EW_RED) begin
      s.phase = PH_NS_GRN; s.last_phase = PH_NS_GRN; s.remaining = cfg.long_ticks;
    end

    // emergency, north-south side
    if (s.pending && s.step == ST_IDLE &&
        (s.last_phase == PH_NS_GRN || s.last_phase == PH_NS_YEL)) begin
      if (s.last_phase == PH_NS_GRN) begin
        s.remaining = cfg.short_ticks;
      end
      s.step = ST_NS_YEL;
    end
    if (s.step == ST_NS_YEL && s.remaining == '0) begin
      s.remaining = cfg.emergency_ticks;
      s.step      = ST_NS_RED;
    end
    if (s.step == ST_NS_RED && s.remaining == '0) begin
      s.step       = ST_IDLE;
      s.pending    = 1'b0;
      s.phase      = PH_EW_GRN;
      s.last_phase = PH_EW_GRN;
      s.remaining  = cfg.long_ticks;
    end
    if (s.pending && s.last_phase == PH_NS_RED && s.step == ST_IDLE) begin
      s.remaining = cfg.emergency_ticks;
      s.step      = ST_NS_RED;
    end

    // emergency, east-west side
    if (s.pending && s.step == ST_IDLE &&
        (s.last_phase == PH_EW_GRN || s.last_phase == PH_EW_YEL)) begin
      if (s.last_phase == PH_EW_GRN) begin
        s.remaining = cfg.short_ticks;
      end
      s.step = ST_EW_YEL;
    end
    if (s.step == ST_EW_YEL && s.remaining == '0) begin
      s.remaining = cfg.emergency_ticks;
      s.step      = ST_EW_RED;
    end
    if (s.step == ST_EW_RED && s.remaining == '0) begin
      s.step       = ST_IDLE;
      s.pending    = 1'b0;
      s.phase      = PH_NS_GRN;
      s.last_phase = PH_NS_GRN;
      s.remaining  = cfg.long_ticks;
    end
    if (s.pending && s.last_phase == PH_EW_RED && s.step == ST_IDLE) begin
      s.remaining = cfg.emergency_ticks;
      s.step      = ST_EW_RED;
    end
  end

  always_comb begin
    ns = LAMP_RED;
    ew = LAMP_RED;
    case (s.step)
      ST_IDLE: begin
        case (s.phase)
          PH_NS_GRN: ns = LAMP_GRN;
          PH_NS_YEL: ns = LAMP_YEL;
          PH_EW_GRN: ew = LAMP_GRN;
          PH_EW_YEL: ew = LAMP_YEL;
          default: begin
            ns = LAMP_RED;
            ew = LAMP_RED;
          end
        endcase
      end
      ST_NS_YEL: ns = LAMP_YEL;
      ST_EW_YEL: ew = LAMP_YEL;
      default: begin
        ns = LAMP_RED;
        ew = LAMP_RED;
      end
    endcase
  end

  assign nxt                     = s;
  assign result.ns_light         = ns;
  assign result.ew_light         = ew;
  assign result.emergency_active = s.pending;

endmodule

@@ hdl/traffic_light_emergency_controller_unit.sv @@
// ----------------------------------------------------------------------------
// traffic_light_emergency_controller_unit
// Two-way crossing light controller with emergency override.
//
//   channel  signals                          role
//   item     item_valid, item_stall, item     tick and emergency press in
//   result   result_valid, result_stall, ...  lamp states and emergency flag
//   config   cfg_we, cfg_index, cfg_data      timing register writes
//
// One item per cycle sustained while result_stall is low; each transfer passes
// through the input register, then the single-pass state update into the
// result register. rst clears the control state and restores the timing
// registers. While result_stall holds a full result register, the input
// register still takes one item; item_stall rises only when both are full.
// ----------------------------------------------------------------------------
module traffic_light_emergency_controller_unit import tlec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [TickW-1:0]     cfg_data
);

  cfg_t       cfg;
  ctl_state_t state;
  ctl_state_t state_next;
  result_t    result_next;
  logic       hold_valid;
  item_t      hold_item;
  logic       advance;
  logic       load;

  assign advance    = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && result_valid && result_stall;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_ticks     <= TickW'(300);
      cfg.long_ticks      <= TickW'(500);
      cfg.emergency_ticks <= TickW'(500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_TICKS:     cfg.short_ticks     <= cfg_data;
        REG_LONG_TICKS:      cfg.long_ticks      <= cfg_data;
        REG_EMERGENCY_TICKS: cfg.emergency_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_item <= item;
    end
  end

  tlec_step u_step (
    .cur    (state),
    .item   (hold_item),
    .cfg    (cfg),
    .nxt    (state_next),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_NS_GRN;
      state.last_phase <= PH_NS_GRN;
      state.step       <= ST_IDLE;
      state.pending    <= 1'b0;
      state.remaining  <= TickW'(500);
      result_valid     <= 1'b0;
    end else begin
      if (advance) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_hold_needs_pending: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_HOLD |-> state.pending)
    else $error("cycle suspended without a pending emergency");

  a_step_needs_pending: assert property (@(posedge clk) disable iff (rst)
    state.step != ST_IDLE |-> state.pending)
    else $error("emergency sequence running without a pending emergency");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (hold_valid && result_valid))
    else $error("item stalled while a stage is free");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("state advanced without a result");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the crossing light controller. A stimulus process
// writes the timing registers while the block is idle and queues tick and
// emergency events. A clocked driver sends them with random gaps, and a
// clocked monitor stalls at random. Every transfer runs through a local model
// of the phase cycle and the emergency sequence, and each lamp result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import tlec_pkg::*;

  localparam int               Limit     = 500000;
  localparam logic [1:0]       RegSpare  = 2'd3;
  localparam logic [TickW-1:0] InitShort = 16'd300;
  localparam logic [TickW-1:0] InitLong  = 16'd500;
  localparam logic [TickW-1:0] InitEmg   = 16'd500;
  localparam logic [TickW-1:0] MaxTicks  = 16'hFFFF;

  logic             clk;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  item_t            item         = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_we       = 1'b0;
  logic [1:0]       cfg_index    = '0;
  logic [TickW-1:0] cfg_data     = '0;

  traffic_light_emergency_controller_unit uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  item_t   crossing_events[$];
  result_t lamp_forecast[$];

  // model copy of the timing registers and control state
  logic [TickW-1:0] short_t, long_t, emg_t;
  phase_t           ph, last_ph;
  emg_step_t        step;
  logic             pend;
  logic [TickW-1:0] rem;

  int  mismatches = 0;
  int  cycles = 0;
  int  events_sent = 0;
  int  presses_sent = 0;
  int  emg_results = 0;
  int  settings_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void enter(phase_t p, logic [TickW-1:0] t);
    ph = p;
    last_ph = p;
    rem = t;
  endfunction

  function automatic result_t advance_crossing(item_t it);
    result_t r;
    if (it.emergency_press) begin
      pend = 1'b1;
      ph = PH_HOLD;
    end
    if (it.tick && rem != 0) rem = rem - 1'b1;

    if (rem == 0 && ph == PH_NS_GRN) enter(PH_NS_YEL, short_t);
    if (rem == 0 && ph == PH_NS_YEL) enter(PH_NS_RED, short_t);
    if (rem == 0 && ph == PH_NS_RED) enter(PH_EW_GRN, long_t);
    if (rem == 0 && ph == PH_EW_GRN) enter(PH_EW_YEL, short_t);
    if (rem == 0 && ph == PH_EW_YEL) enter(PH_EW_RED, short_t);
    if (rem == 0 && ph == PH_EW_RED) enter(PH_NS_GRN, long_t);

    if (pend && (last_ph == PH_NS_GRN || last_ph == PH_NS_YEL) && step == ST_IDLE) begin
      if (last_ph == PH_NS_GRN) rem = short_t;
      step = ST_NS_YEL;
    end
    if (step == ST_NS_YEL && rem == 0) begin
      rem = emg_t;
      step = ST_NS_RED;
    end
    if (step == ST_NS_RED && rem == 0) begin
      step = ST_IDLE;
      pend = 1'b0;
      enter(PH_EW_GRN, long_t);
    end
    if (pend && last_ph == PH_NS_RED && step == ST_IDLE) begin
      rem = emg_t;
      step = ST_NS_RED;
    end

    if (pend && (last_ph == PH_EW_GRN || last_ph == PH_EW_YEL) && step == ST_IDLE) begin
      if (last_ph == PH_EW_GRN) rem = short_t;
      step = ST_EW_YEL;
    end
    if (step == ST_EW_YEL && rem == 0) begin
      rem = emg_t;
      step = ST_EW_RED;
    end
    if (step == ST_EW_RED && rem == 0) begin
      step = ST_IDLE;
      pend = 1'b0;
      enter(PH_NS_GRN, long_t);
    end
    if (pend && last_ph == PH_EW_RED && step == ST_IDLE) begin
      rem = emg_t;
      step = ST_EW_RED;
    end

    r.ns_light = LAMP_RED;
    r.ew_light = LAMP_RED;
    if (step == ST_IDLE) begin
      if (ph == PH_NS_GRN) r.ns_light = LAMP_GRN;
      else if (ph == PH_NS_YEL) r.ns_light = LAMP_YEL;
      else if (ph == PH_EW_GRN) r.ew_light = LAMP_GRN;
      else if (ph == PH_EW_YEL) r.ew_light = LAMP_YEL;
    end else if (step == ST_NS_YEL) begin
      r.ns_light = LAMP_YEL;
    end else if (step == ST_EW_YEL) begin
      r.ew_light = LAMP_YEL;
    end
    r.emergency_active = pend;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) begin
        lamp_forecast.push_back(advance_crossing(item));
        events_sent++;
        if (item.emergency_press) presses_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (crossing_events.size() != 0) begin
          if (!quiet && $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(1, 15) - 1;
            item_valid <= 1'b0;
          end else begin
            item_valid <= 1'b1;
            item <= crossing_events.pop_front();
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (lamp_forecast.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ns=%0d ew=%0d emg=%0d",
                     result.ns_light, result.ew_light, result.emergency_active);
        end else begin
          want = lamp_forecast.pop_front();
          if (want.emergency_active) emg_results++;
          if (result.ns_light !== want.ns_light || result.ew_light !== want.ew_light ||
              result.emergency_active !== want.emergency_active) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ns=%0d ew=%0d emg=%0d, got ns=%0d ew=%0d emg=%0d",
                       want.ns_light, want.ew_light, want.emergency_active,
                       result.ns_light, result.ew_light, result.emergency_active);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(1, 15) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == Limit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               lamp_forecast.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void queue_event(logic t, logic p);
    item_t it;
    it.tick = t;
    it.emergency_press = p;
    crossing_events.push_back(it);
  endfunction

  function automatic void queue_random(int n);
    for (int i = 0; i < n; i++)
      queue_event($urandom_range(0, 3) != 0, $urandom_range(0, 11) == 0);
  endfunction

  task automatic wait_settled();
    @(negedge clk);
    while (crossing_events.size() != 0 || item_valid || lamp_forecast.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_timing(logic [1:0] idx, logic [TickW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SHORT_TICKS:     short_t = val;
      REG_LONG_TICKS:      long_t = val;
      REG_EMERGENCY_TICKS: emg_t = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [TickW-1:0] s, logic [TickW-1:0] l, logic [TickW-1:0] e);
    wait_settled();
    write_timing(REG_EMERGENCY_TICKS, e);
    write_timing(REG_LONG_TICKS, l);
    write_timing(REG_SHORT_TICKS, s);
    settings_seen++;
    @(negedge clk);
  endtask

  initial begin
    short_t = InitShort;
    long_t  = InitLong;
    emg_t   = InitEmg;
    ph      = PH_NS_GRN;
    last_ph = PH_NS_GRN;
    step    = ST_IDLE;
    pend    = 1'b0;
    rem     = InitLong;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset timing: quiet crossing, then a press with and without a tick
    settings_seen++;
    queue_event(1'b0, 1'b0);
    queue_event(1'b1, 1'b0);
    queue_event(1'b0, 1'b1);
    queue_event(1'b1, 1'b1);
    queue_event(1'b1, 1'b0);
    queue_event(1'b0, 1'b0);

    // shortest timing: walk the cycle, press in several phases and mid-sequence
    set_timing(16'd1, 16'd1, 16'd1);
    repeat (7) queue_event(1'b1, 1'b0);
    queue_event(1'b0, 1'b1);
    queue_event(1'b1, 1'b1);
    queue_event(1'b1, 1'b0);
    queue_event(1'b1, 1'b1);
    queue_event(1'b1, 1'b0);
    queue_event(1'b1, 1'b0);
    queue_event(1'b0, 1'b1);
    queue_random(150);

    // zero durations: countdown stays at zero, chained transitions
    set_timing(16'd0, 16'd0, 16'd0);
    queue_event(1'b1, 1'b0);
    queue_event(1'b0, 1'b1);
    queue_event(1'b1, 1'b1);
    queue_random(100);

    set_timing(16'd2, 16'd5, 16'd3);
    queue_random(100);
    wait_settled();
    queue_random(100);

    for (int k = 0; k < 5; k++) begin
      set_timing(TickW'($urandom_range(0, 6)), TickW'($urandom_range(0, 6)),
                 TickW'($urandom_range(0, 6)));
      queue_random(80);
    end

    set_timing(MaxTicks, MaxTicks, MaxTicks);
    queue_random(60);

    set_timing(TickW'($urandom_range(1, 4)), TickW'($urandom_range(1, 8)),
               TickW'($urandom_range(1, 4)));
    wait_settled();
    write_timing(RegSpare, 16'd0);
    @(negedge clk);
    quiet = 1'b1;
    queue_random(150);

    wait_settled();
    repeat (4) @(posedge clk);
    $display("sent %0d events under %0d timing settings, %0d emergency presses",
             events_sent, settings_seen, presses_sent);
    $display("%0d results showed an active emergency, %0d mismatches", emg_results,
             mismatches);
    if (mismatches == 0 && lamp_forecast.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ traffic_light_emergency_controller_unit.f @@
hdl/tlec_pkg.sv
hdl/tlec_step.sv
hdl/traffic_light_emergency_controller_unit.sv
tb/tb.sv
